FILE: src/rbb_pkg.sv
package rbb_pkg;

	localparam int MAX_ATLAS_LOG2_DEF = 11;
	localparam int MAX_SRC_DIM_DEF    = 4096;
	localparam int QUEUE_DEPTH        = 4;

	localparam logic [3:0] ATLAS_LOG2_RESET = 4'd10;

	// command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// configuration register indexes
	localparam logic [3:0] CFG_ATLAS_LOG2 = 4'd0;
	localparam logic [3:0] CFG_AMPLIFY    = 4'd1;

	// one pixel pair, resolved to coordinates, waiting for the address maths
	typedef struct packed {
		logic [12:0] sy;
		logic [12:0] stride;
		logic [12:0] sx;
		logic [21:0] drow;
		logic [21:0] dcol;
		logic [3:0]  lg;
		logic        last;
	} rbb_entry_t;

	typedef struct packed {
		logic       valid;
		rbb_entry_t entry;
	} rbb_push_t;

endpackage

FILE: src/rotate_bleed_blit_address_gen_top.sv
// Rotated blit address generator with optional replicated border.
// Input channel (in_valid/in_ready): command 0 loads a copy job from the
// rectangle fields, command 1 is a tick asking for the next pixel pair.
// A load gives no result; a tick while no job runs gives none either.
// Output channel (out_valid/out_ready): one source/destination pixel index
// pair per tick of a running job, in destination raster order, with last
// set on the final pair.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 is the atlas
// side log2, index 1 the amplify (border) flag.
// A tick's pair is registered in the queue, the first back stage and then
// the output register. Throughput: one item per cycle while out_ready
// is high; the front keeps the job counters and resolves coordinates
// combinationally, the back does the stride multiply and the final add
// in two registered stages. A four-entry queue sits between them. When the
// receiver stalls, the back holds its result and the queue fills; in_ready
// falls once it is full. Reset clears the job, the queue and the pipeline;
// the atlas log2 returns to 10 and amplify to 0.
module rotate_bleed_blit_address_gen_top #(
	parameter int MAX_ATLAS_LOG2 = rbb_pkg::MAX_ATLAS_LOG2_DEF,
	parameter int MAX_SRC_DIM    = rbb_pkg::MAX_SRC_DIM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [10:0] draw_x,
	input  logic [10:0] draw_y,
	input  logic [11:0] copy_width,
	input  logic [11:0] copy_height,
	input  logic [11:0] src_left,
	input  logic [11:0] src_top,
	input  logic [12:0] src_row_pixels,
	input  logic        rotated,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] src_pixel_index,
	output logic [21:0] dst_pixel_index,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [3:0]  cfg_data
);

	rbb_pkg::rbb_push_t  push;
	rbb_pkg::rbb_entry_t head;
	logic                queue_full, head_valid, pop;

	assign cfg_ready = 1'b1;

	rbb_front #(
		.MAX_ATLAS_LOG2(MAX_ATLAS_LOG2),
		.MAX_SRC_DIM   (MAX_SRC_DIM)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.draw_x        (draw_x),
		.draw_y        (draw_y),
		.copy_width    (copy_width),
		.copy_height   (copy_height),
		.src_left      (src_left),
		.src_top       (src_top),
		.src_row_pixels(src_row_pixels),
		.rotated       (rotated),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.queue_full    (queue_full),
		.push          (push)
	);

	rbb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.full      (queue_full),
		.head_valid(head_valid),
		.head      (head)
	);

	rbb_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.src_pixel_index(src_pixel_index),
		.dst_pixel_index(dst_pixel_index),
		.last           (last)
	);

endmodule

FILE: src/rbb_front.sv
module rbb_front #(
	parameter int MAX_ATLAS_LOG2 = rbb_pkg::MAX_ATLAS_LOG2_DEF,
	parameter int MAX_SRC_DIM    = rbb_pkg::MAX_SRC_DIM_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic [10:0]        draw_x,
	input  logic [10:0]        draw_y,
	input  logic [11:0]        copy_width,
	input  logic [11:0]        copy_height,
	input  logic [11:0]        src_left,
	input  logic [11:0]        src_top,
	input  logic [12:0]        src_row_pixels,
	input  logic               rotated,
	input  logic               cfg_valid,
	input  logic [3:0]         cfg_index,
	input  logic [3:0]         cfg_data,
	input  logic               queue_full,
	output rbb_pkg::rbb_push_t push
);

	logic [3:0]  atlas_log2_q;
	logic        amplify_q;
	logic [10:0] job_draw_x_q, job_draw_y_q;
	logic [11:0] job_width_q, job_height_q, job_src_left_q, job_src_top_q;
	logic [12:0] job_stride_q;
	logic        job_rotated_q;
	logic [12:0] col_pos_q, row_pos_q;
	logic        busy_q;

	logic               accept, tick;
	logic [11:0]        dw_m1, dh_m1, cu, cv;
	logic [12:0]        col_end, row_end;
	logic signed [13:0] u_s, v_s;
	logic               row_done, is_last;
	logic [12:0]        stride_sat;
	logic [3:0]         lg;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign tick     = accept && (command == rbb_pkg::CMD_TICK) && busy_q;

	always_comb begin
		dw_m1   = (job_rotated_q ? job_height_q : job_width_q) - 12'd1;
		dh_m1   = (job_rotated_q ? job_width_q : job_height_q) - 12'd1;
		col_end = {1'b0, dw_m1} + {11'd0, amplify_q, 1'b0};
		row_end = {1'b0, dh_m1} + {11'd0, amplify_q, 1'b0};
		u_s     = $signed({1'b0, col_pos_q}) - $signed({13'd0, amplify_q});
		v_s     = $signed({1'b0, row_pos_q}) - $signed({13'd0, amplify_q});

		// clamp into the region: the border repeats the edge pixels
		if (u_s < 0)
			cu = 12'd0;
		else if (u_s > $signed({2'b00, dw_m1}))
			cu = dw_m1;
		else
			cu = u_s[11:0];
		if (v_s < 0)
			cv = 12'd0;
		else if (v_s > $signed({2'b00, dh_m1}))
			cv = dh_m1;
		else
			cv = v_s[11:0];

		row_done = col_pos_q >= col_end;
		is_last  = row_done && (row_pos_q >= row_end);

		if (atlas_log2_q > 4'(MAX_ATLAS_LOG2))
			lg = 4'(MAX_ATLAS_LOG2);
		else
			lg = atlas_log2_q;

		if (32'(src_row_pixels) > MAX_SRC_DIM)
			stride_sat = 13'(MAX_SRC_DIM);
		else
			stride_sat = src_row_pixels;

		push.valid        = tick;
		push.entry.stride = job_stride_q;
		if (job_rotated_q) begin
			push.entry.sx = {1'b0, job_src_left_q} + {1'b0, cv};
			push.entry.sy = {1'b0, job_src_top_q} + {1'b0, 12'(job_height_q - 12'd1 - cu)};
		end else begin
			push.entry.sx = {1'b0, job_src_left_q} + {1'b0, cu};
			push.entry.sy = {1'b0, job_src_top_q} + {1'b0, cv};
		end
		push.entry.drow = {11'd0, job_draw_y_q} + {{8{v_s[13]}}, v_s};
		push.entry.dcol = {11'd0, job_draw_x_q} + {{8{u_s[13]}}, u_s};
		push.entry.lg   = lg;
		push.entry.last = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_log2_q <= rbb_pkg::ATLAS_LOG2_RESET;
			amplify_q    <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				rbb_pkg::CFG_ATLAS_LOG2: atlas_log2_q <= cfg_data;
				rbb_pkg::CFG_AMPLIFY:    amplify_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_draw_x_q   <= '0;
			job_draw_y_q   <= '0;
			job_width_q    <= '0;
			job_height_q   <= '0;
			job_src_left_q <= '0;
			job_src_top_q  <= '0;
			job_stride_q   <= '0;
			job_rotated_q  <= 1'b0;
			col_pos_q      <= '0;
			row_pos_q      <= '0;
			busy_q         <= 1'b0;
		end else if (accept && command == rbb_pkg::CMD_LOAD) begin
			job_draw_x_q   <= draw_x;
			job_draw_y_q   <= draw_y;
			job_width_q    <= copy_width;
			job_height_q   <= copy_height;
			job_src_left_q <= src_left;
			job_src_top_q  <= src_top;
			job_stride_q   <= stride_sat;
			job_rotated_q  <= rotated;
			col_pos_q      <= '0;
			row_pos_q      <= '0;
			busy_q         <= (copy_width != 12'd0) && (copy_height != 12'd0);
		end else if (tick) begin
			if (is_last) begin
				busy_q    <= 1'b0;
				col_pos_q <= '0;
				row_pos_q <= '0;
			end else if (row_done) begin
				col_pos_q <= '0;
				row_pos_q <= row_pos_q + 13'd1;
			end else begin
				col_pos_q <= col_pos_q + 13'd1;
			end
		end
	end

endmodule

FILE: src/rbb_queue.sv
module rbb_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  rbb_pkg::rbb_push_t  push,
	input  logic                pop,
	output logic                full,
	output logic                head_valid,
	output rbb_pkg::rbb_entry_t head
);

	localparam int PW = $clog2(rbb_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(rbb_pkg::QUEUE_DEPTH + 1);

	rbb_pkg::rbb_entry_t slot_q [rbb_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign full       = count_q == CW'(rbb_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = slot_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push.valid)
			slot_q[wr_ptr_q] <= push.entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid)
				wr_ptr_q <= (wr_ptr_q == PW'(rbb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(rbb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push.valid, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

FILE: src/rbb_back.sv
module rbb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  rbb_pkg::rbb_entry_t head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [23:0]         src_pixel_index,
	output logic [21:0]         dst_pixel_index,
	output logic                last
);

	logic        v_s1;
	logic [23:0] prod_s1;
	logic [12:0] sx_s1;
	logic [21:0] dst_s1;
	logic        last_s1;
	logic        out_valid_q;
	logic [23:0] src_q;
	logic [21:0] dst_q;
	logic        last_q;

	logic        adv_out, adv_s1;
	logic [25:0] prod;

	assign adv_out = !out_valid_q || out_ready;
	assign adv_s1  = !v_s1 || adv_out;
	assign pop     = adv_s1;
	assign prod    = head.sy * head.stride;

	always_ff @(posedge clk) begin
		if (adv_s1 && head_valid) begin
			prod_s1 <= prod[23:0];
			sx_s1   <= head.sx;
			dst_s1  <= (head.drow << head.lg) + head.dcol;
			last_s1 <= head.last;
		end
		if (adv_out && v_s1) begin
			src_q  <= prod_s1 + {11'd0, sx_s1};
			dst_q  <= dst_s1;
			last_q <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1)
				v_s1 <= head_valid;
			if (adv_out)
				out_valid_q <= v_s1;
		end
	end

	assign out_valid       = out_valid_q;
	assign src_pixel_index = src_q;
	assign dst_pixel_index = dst_q;
	assign last            = last_q;

endmodule

FILE: src/rbb_checker.sv
module rbb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [23:0] src_pixel_index,
	input logic [21:0] dst_pixel_index,
	input logic        last,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(src_pixel_index)
			&& $stable(dst_pixel_index) && $stable(last))
		else $error("result changed while stalled");

	// the reset is asynchronous, so no result is shown while it is held
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result shown during reset");

	// the queue only fills behind a result that waits
	a_full_means_backed_up: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind rotate_bleed_blit_address_gen_top rbb_checker u_rbb_checker (.*);
